FILE: rtl/alarm_slot_scheduler_macros.svh
// Assertion macros shared by the alarm slot scheduler RTL
`ifndef ALARM_SLOT_SCHEDULER_MACROS_SVH
`define ALARM_SLOT_SCHEDULER_MACROS_SVH

// check that holds when not in reset
`define ASS_CHECK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASS_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: rtl/ass_pkg.sv
// Package for the alarm slot scheduler: constants, types, helpers
package ass_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 8;
    localparam int unsigned QUANTUM_DEF    = 4;
    localparam logic [31:0] NO_ALARM       = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        K_ADD_ONCE = 2'd0,
        K_ADD_PER  = 2'd1,
        K_FIRE     = 2'd2,
        K_PLAN     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        M_OFF  = 2'd0,
        M_ONCE = 2'd1,
        M_PER  = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DIV,
        S_ADD_WR,
        S_FIRE_WR,
        S_OUT,
        S_FIRE_OUT
    } t_state;

    // divider request to the modulo unit
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_div_rsp;

endpackage

FILE: rtl/ass_ram.sv
// Generic single-port-write RAM with registered read
module ass_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/ass_mod.sv
// Restoring bit-serial 32-bit modulo unit, one bit per cycle
module ass_mod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ass_pkg::t_div_req   i_req,
    output ass_pkg::t_div_rsp   o_rsp
);
    import ass_pkg::*;

    logic [31:0] r_num, n_num;
    logic [31:0] r_den;
    logic [32:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_shift;

    always_comb begin
        w_shift = {r_rem[31:0], r_num[31]};
        n_num   = r_num;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_num  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[30:0], 1'b0};
            n_rem = (w_shift >= {1'b0, r_den}) ? w_shift - {1'b0, r_den} : w_shift;
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.divisor;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[31:0];
endmodule

FILE: rtl/alarm_slot_scheduler.sv
// Alarm slot scheduler: slot table in RAM, request sequencer, modulo unit
// Add: a periodic add does not wait for the modulo unit when now is before the offset,
// and takes up to two modulo passes when the offset exceeds the interval.
// Fire: reads each slot; a due periodic slot also gets a modulo pass and a rewrite.
// Plan: scans for the earliest expiry until one is due. One request at a time; the slot scan
// and the bit-serial modulo unit set the rate. Reset (synchronous, low) clears all slot modes,
// the handle counter and the planned quantum at once; no clearing pass.
module alarm_slot_scheduler #(
    parameter int unsigned SLOT_COUNT      = ass_pkg::SLOT_COUNT_DEF,
    parameter int unsigned QUANTUM_SECONDS = ass_pkg::QUANTUM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now_seconds,
    input  logic [15:0] i_delay_seconds,
    input  logic [31:0] i_interval_seconds,
    input  logic [15:0] i_offset_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_handle,
    output logic [31:0] o_time_seconds,
    output logic        o_rearm_request,
    output logic        o_last
);
    import ass_pkg::*;
    `include "alarm_slot_scheduler_macros.svh"

    localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned MAX_RES = 8;
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);

    // slot word: handle, offset, interval, expiry
    localparam int unsigned SW = 8 + 16 + 32 + 32;

    logic [SLOT_COUNT-1:0] r_on, n_on;
    logic [SLOT_COUNT-1:0] r_per, n_per;
    t_state      r_st, n_st;
    t_kind       r_kind, n_kind;
    logic [31:0] r_now, n_now;
    logic [31:0] r_dly, n_dly;
    logic [31:0] r_iv, n_iv;
    logic [31:0] r_off, n_off;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_slot, n_slot;
    logic        r_found, n_found;
    logic [31:0] r_min, n_min;
    logic [7:0]  r_hcnt, n_hcnt;
    logic [31:0] r_plan, n_plan;
    logic [3:0]  r_nres, n_nres;
    logic [31:0] r_exp, n_exp;
    logic [7:0]  r_hd, n_hd;
    logic [31:0] r_base, n_base;
    logic        r_pv, n_pv;
    logic [7:0]  r_ph, n_ph;
    logic [31:0] r_pt, n_pt;
    logic        r_ov, n_ov;
    logic [7:0]  r_oh, n_oh;
    logic [31:0] r_ot, n_ot;
    logic        r_orr, n_orr;
    logic        r_ol, n_ol;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [SW-1:0] w_wdata, w_rdata;
    logic [AW-1:0] w_raddr;
    t_div_req      w_req;
    t_div_rsp      w_rsp;
    logic [7:0]    w_rh;
    logic [15:0]   w_roff;
    logic [31:0]   w_riv, w_rexp;
    logic          w_out_free;
    logic [7:0]    w_nh;
    logic          w_more;

    ass_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_slots (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    ass_mod u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign {w_rh, w_roff, w_riv, w_rexp} = w_rdata;
    assign w_out_free = !r_ov || !i_stall;
    assign o_stall    = (r_st != S_IDLE);
    assign w_nh       = (r_hcnt == 8'hFF) ? 8'd1 : r_hcnt + 8'd1;
    assign w_raddr    = r_idx;
    // another due slot may still be handled after this one
    assign w_more     = (r_idx != LAST_SLOT) && (r_nres != 4'(MAX_RES - 1));

    always_comb begin
        n_st = r_st; n_kind = r_kind; n_now = r_now; n_dly = r_dly; n_iv = r_iv;
        n_off = r_off; n_idx = r_idx; n_slot = r_slot; n_found = r_found;
        n_min = r_min; n_hcnt = r_hcnt; n_plan = r_plan; n_nres = r_nres;
        n_exp = r_exp; n_hd = r_hd; n_base = r_base; n_on = r_on; n_per = r_per;
        n_pv = r_pv; n_ph = r_ph; n_pt = r_pt;
        n_ov = r_ov && i_stall; n_oh = r_oh; n_ot = r_ot; n_orr = r_orr; n_ol = r_ol;
        w_we = 1'b0; w_waddr = r_slot; w_wdata = {r_hd, r_off[15:0], r_iv, r_exp};
        w_req = '0;
        case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind  = t_kind'(i_kind);
                    n_now   = i_now_seconds / QUANTUM_SECONDS;
                    n_dly   = 32'(i_delay_seconds / QUANTUM_SECONDS);
                    n_iv    = i_interval_seconds / QUANTUM_SECONDS;
                    n_off   = 32'(i_offset_seconds / QUANTUM_SECONDS);
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_min   = NO_ALARM;
                    n_nres  = '0;
                    n_pv    = 1'b0;
                    n_st    = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                // add requests need no read: pick the first free slot from the mode bits
                if (r_kind == K_ADD_ONCE || r_kind == K_ADD_PER) begin
                    n_found = 1'b0;
                    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                        if (!r_on[i]) begin
                            n_found = 1'b1;
                            n_slot  = AW'(i);
                        end
                    end
                    if (!n_found || (r_kind == K_ADD_PER && r_iv == '0)) begin
                        n_st = S_OUT;
                        n_hd = '0; n_exp = '0; n_found = 1'b0;
                    end else begin
                        n_hd   = w_nh;
                        n_hcnt = w_nh;
                        if (r_kind == K_ADD_ONCE) begin
                            n_exp = r_now + r_dly;
                            n_st  = S_ADD_WR;
                        end else begin
                            if (r_iv < r_off) begin
                                n_st           = S_DIV;
                                w_req.start    = 1'b1;
                                w_req.dividend = r_off;
                                w_req.divisor  = r_iv;
                                n_base = '0;
                            end else begin
                                n_st           = S_DIV;
                                w_req.start    = 1'b1;
                                w_req.dividend = r_now - r_off;
                                w_req.divisor  = r_iv;
                                n_base = 32'd1;
                            end
                        end
                    end
                end else begin
                    n_st = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                // RAM word for r_idx is valid here
                if (r_kind == K_PLAN) begin
                    if (r_on[r_idx] && w_rexp < r_min) begin
                        n_min = w_rexp;
                    end
                    if ((r_on[r_idx] && (n_min <= r_now)) || r_idx == LAST_SLOT) begin
                        n_st = S_OUT;
                        n_hd = '0;
                        if (n_min == NO_ALARM) begin
                            n_exp = '0;
                        end else begin
                            n_plan = n_min;
                            n_exp  = n_min;
                        end
                    end else begin
                        n_idx = r_idx + AW'(1);
                        n_st  = S_SCAN_RD;
                    end
                end else begin
                    if (r_on[r_idx] && !(r_plan < w_rexp)) begin
                        n_slot = r_idx;
                        n_hd   = w_rh;
                        n_exp  = w_rexp;
                        n_iv   = w_riv;
                        n_off  = 32'(w_roff);
                        if (r_per[r_idx]) begin
                            w_req.start    = 1'b1;
                            w_req.dividend = r_plan - 32'(w_roff);
                            w_req.divisor  = w_riv;
                            n_st  = S_DIV;
                        end else begin
                            n_on[r_idx] = 1'b0;
                            n_st = S_FIRE_OUT;
                        end
                    end else if (r_idx == LAST_SLOT) begin
                        if (r_pv) begin
                            // held word is the final one
                            n_hd    = r_ph;
                            n_exp   = r_pt;
                            n_found = 1'b1;
                            n_pv    = 1'b0;
                            n_st    = S_OUT;
                        end else begin
                            n_st = S_IDLE;
                        end
                    end else begin
                        n_idx = r_idx + AW'(1);
                        n_st  = S_SCAN_RD;
                    end
                end
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    if (r_kind == K_FIRE) begin
                        n_base = r_plan + r_iv - w_rsp.rem;
                        n_st   = S_FIRE_WR;
                    end else if (r_base == '0) begin
                        // offset reduced; restart with the grid step
                        n_off = w_rsp.rem;
                        if (r_now < w_rsp.rem) begin
                            n_exp = w_rsp.rem;
                            n_st  = S_ADD_WR;
                        end else begin
                            w_req.start    = 1'b1;
                            w_req.dividend = r_now - w_rsp.rem;
                            w_req.divisor  = r_iv;
                            n_base = 32'd1;
                        end
                    end else begin
                        n_exp = r_now + r_iv - w_rsp.rem;
                        n_st  = S_ADD_WR;
                    end
                end else if (r_kind == K_ADD_PER && r_base == 32'd1 && r_now < r_off
                             && r_iv >= r_off) begin
                    // now before offset: expiry is the offset itself
                    n_exp = r_off;
                    n_st  = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                w_we  = 1'b1;
                n_on[r_slot]  = 1'b1;
                n_per[r_slot] = (r_kind == K_ADD_PER);
                n_found = 1'b1;
                n_st  = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ov  = 1'b1;
                    n_oh  = r_hd;
                    n_ot  = 32'(r_exp * QUANTUM_SECONDS);
                    n_orr = (r_kind != K_PLAN) && r_found;
                    n_ol  = 1'b1;
                    n_st  = S_IDLE;
                end
            end
            S_FIRE_WR: begin
                w_we    = 1'b1;
                w_wdata = {r_hd, r_off[15:0], r_iv, r_base};
                n_st    = S_FIRE_OUT;
            end
            S_FIRE_OUT: begin
                // the held word goes out with last clear; this one is held until the
                // scan shows whether it is the final word
                if (!r_pv || w_out_free) begin
                    if (r_pv) begin
                        n_ov  = 1'b1;
                        n_oh  = r_ph;
                        n_ot  = 32'(r_pt * QUANTUM_SECONDS);
                        n_orr = 1'b1;
                        n_ol  = 1'b0;
                    end
                    n_nres = r_nres + 4'd1;
                    if (!w_more) begin
                        n_pv    = 1'b0;
                        n_found = 1'b1;
                        n_st    = S_OUT;
                    end else begin
                        n_pv  = 1'b1;
                        n_ph  = r_hd;
                        n_pt  = r_exp;
                        n_idx = r_idx + AW'(1);
                        n_st  = S_SCAN_RD;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_on   <= '0;
            r_per  <= '0;
            r_hcnt <= '0;
            r_plan <= '0;
            r_ov   <= 1'b0;
            r_nres <= '0;
            r_pv   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_on   <= n_on;
            r_per  <= n_per;
            r_hcnt <= n_hcnt;
            r_plan <= n_plan;
            r_ov   <= n_ov;
            r_nres <= n_nres;
            r_pv   <= n_pv;
        end
        r_kind <= n_kind; r_now <= n_now; r_dly <= n_dly; r_iv <= n_iv; r_off <= n_off;
        r_idx <= n_idx; r_slot <= n_slot; r_found <= n_found; r_min <= n_min;
        r_exp <= n_exp; r_hd <= n_hd; r_base <= n_base;
        r_ph <= n_ph; r_pt <= n_pt;
        r_oh <= n_oh; r_ot <= n_ot; r_orr <= n_orr; r_ol <= n_ol;
    end

    assign o_valid         = r_ov;
    assign o_handle        = r_oh;
    assign o_time_seconds  = r_ot;
    assign o_rearm_request = r_orr;
    assign o_last          = r_ol;

    `ASS_NEXT(a_hcnt_nz, i_clk, i_rst_n, w_we && r_st == S_ADD_WR, r_hcnt != 8'd0,
        "handle counter zero after add")
    `ASS_CHECK(a_per_on, i_clk, i_rst_n, (r_per & ~r_on) == '0,
        "periodic flag inconsistent")
    `ASS_CHECK(a_wr_state, i_clk, i_rst_n,
        !w_we || r_st == S_ADD_WR || r_st == S_FIRE_WR, "slot write outside write state")
endmodule
